@@ src/nfa_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the epsilon-NFA acceptor.
`default_nettype none
package nfa_pkg;

  localparam int NUM_STATES  = 16;
  localparam int NUM_SYMBOLS = 16;

  localparam int STATE_W  = $clog2(NUM_STATES);
  localparam int SYM_W    = $clog2(NUM_SYMBOLS);
  localparam int ADDR_W   = STATE_W + SYM_W;
  localparam int TBL_DEPTH = 1 << ADDR_W;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int MASK_W  = 16;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 24;
  localparam int CFG_W   = 16;

  typedef logic [NUM_STATES-1:0] set_t;

  typedef enum logic [OP_W-1:0] {
    OP_WR_SYM  = 2'd0,
    OP_WR_EPS  = 2'd1,
    OP_RESTART = 2'd2,
    OP_FEED    = 2'd3
  } op_t;

  typedef enum logic {
    CFG_START  = 1'b0,
    CFG_ACCEPT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic               load;
    logic               wr;
    logic               seed;
    logic               clr_work;
    logic               rd_en;
    logic [STATE_W-1:0] rd_state;
    logic               close_step;
    logic               commit;
    logic               deliver;
  } cmd_t;

  typedef struct packed {
    logic closed;
  } sts_t;

endpackage
`default_nettype wire

@@ src/nfa_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module nfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule
`default_nettype wire

@@ src/nfa_ctrl.sv @@
// Controller state machine sequencing table writes, successor gathering and closure rounds.
`default_nettype none
module nfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire nfa_pkg::op_t  in_op,
  input  wire logic          slot_free,
  input  wire nfa_pkg::sts_t sts,
  output logic               in_ready,
  output nfa_pkg::cmd_t      cmd
);
  import nfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR,
    S_GATHER,
    S_DRAIN,
    S_CLOSE,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [STATE_W-1:0] cnt_r, cnt_nxt;
  logic               fire;

  assign in_ready = (state_r == S_IDLE);
  assign fire     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.rd_state = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (fire) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          case (in_op)
            OP_WR_SYM, OP_WR_EPS: state_nxt = S_WR;
            OP_RESTART: begin
              cmd.seed  = 1'b1;
              state_nxt = S_CLOSE;
            end
            default: begin
              cmd.clr_work = 1'b1;
              state_nxt    = S_GATHER;
            end
          endcase
        end
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_DONE;
      end
      S_GATHER: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == STATE_W'(NUM_STATES - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CLOSE;
      end
      S_CLOSE: begin
        cmd.close_step = 1'b1;
        if (sts.closed) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.deliver = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> !in_ready)
    else $error("controller accepted a word while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deliver |-> slot_free)
    else $error("result delivered into an occupied output register");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> (state_r == S_CLOSE))
    else $error("gather did not proceed to closure");

endmodule
`default_nettype wire

@@ src/nfa_dp.sv @@
// Datapath: item and configuration registers, transition tables, active set and closure logic.
`default_nettype none
module nfa_dp (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire nfa_pkg::cmd_t           cmd,
  input  wire nfa_pkg::op_t            in_op,
  input  wire logic [nfa_pkg::IDX_W-1:0]  in_state,
  input  wire logic [nfa_pkg::IDX_W-1:0]  in_symbol,
  input  wire logic [nfa_pkg::MASK_W-1:0] in_target,
  input  wire logic                    cfg_we,
  input  wire nfa_pkg::cfg_idx_t       cfg_index,
  input  wire logic [nfa_pkg::CFG_W-1:0]  cfg_wdata,
  output nfa_pkg::sts_t                sts,
  output logic                         res_accepted,
  output logic [nfa_pkg::MASK_W-1:0]   res_active,
  output logic                         res_empty
);
  import nfa_pkg::*;

  op_t               op_r;
  logic [IDX_W-1:0]  st_r;
  logic [IDX_W-1:0]  sym_r;
  logic [MASK_W-1:0] tgt_r;
  logic [IDX_W-1:0]  start_r;
  logic [MASK_W-1:0] acc_mask_r;

  set_t              active_r;
  set_t              work_r, work_nxt;
  set_t              eps_r [NUM_STATES];
  set_t              eps_union;
  logic [TBL_DEPTH-1:0] sym_vld_r;

  logic              st_ok, sym_ok, start_ok;
  logic              sym_we;
  logic [ADDR_W-1:0] ram_addr;
  set_t              ram_q;
  logic              rd_vld_r;
  logic              acc_en_r;

  assign st_ok    = (32'(st_r) < NUM_STATES);
  assign sym_ok   = (32'(sym_r) < NUM_SYMBOLS);
  assign start_ok = (32'(start_r) < NUM_STATES);
  assign sym_we   = cmd.wr && (op_r == OP_WR_SYM) && st_ok && sym_ok;

  always_comb begin
    if (cmd.wr) begin
      ram_addr = {STATE_W'(st_r), SYM_W'(sym_r)};
    end else begin
      ram_addr = {cmd.rd_state, SYM_W'(sym_r)};
    end
  end

  nfa_ram #(
    .WIDTH (NUM_STATES),
    .DEPTH (TBL_DEPTH)
  ) u_sym_tbl (
    .clk   (clk),
    .we    (sym_we),
    .addr  (ram_addr),
    .wdata (NUM_STATES'(tgt_r)),
    .rdata (ram_q)
  );

  always_comb begin
    eps_union = '0;
    for (int s = 0; s < NUM_STATES; s++) begin
      if (work_r[s]) begin
        eps_union = eps_union | eps_r[s];
      end
    end
  end

  assign sts.closed = ((eps_union & ~work_r) == '0);

  always_comb begin
    work_nxt = work_r;
    if (cmd.seed) begin
      work_nxt = start_ok ? (NUM_STATES'(1) << start_r) : '0;
    end else if (cmd.clr_work) begin
      work_nxt = '0;
    end else if (cmd.close_step) begin
      work_nxt = work_r | eps_union;
    end else if (acc_en_r && rd_vld_r) begin
      work_nxt = work_r | ram_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      st_r  <= in_state;
      sym_r <= in_symbol;
      tgt_r <= in_target;
    end
    work_r   <= work_nxt;
    rd_vld_r <= sym_vld_r[ram_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= '0;
      acc_mask_r <= '0;
      active_r   <= '0;
      sym_vld_r  <= '0;
      acc_en_r   <= 1'b0;
      for (int s = 0; s < NUM_STATES; s++) begin
        eps_r[s] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START:  start_r    <= IDX_W'(cfg_wdata);
          CFG_ACCEPT: acc_mask_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (sym_we) begin
        sym_vld_r[ram_addr] <= 1'b1;
      end
      if (cmd.wr && (op_r == OP_WR_EPS) && st_ok) begin
        eps_r[STATE_W'(st_r)] <= NUM_STATES'(tgt_r);
      end
      acc_en_r <= cmd.rd_en && sym_ok && active_r[cmd.rd_state];
      if (cmd.commit) begin
        active_r <= work_r;
      end
    end
  end

  assign res_active   = MASK_W'(active_r);
  assign res_accepted = ((MASK_W'(active_r) & acc_mask_r) != '0);
  assign res_empty    = (active_r == '0);

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.closed)
    else $error("active set committed before closure settled");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.close_step |=> ((work_r & $past(work_r)) == $past(work_r)))
    else $error("closure round lost a state");

  assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(active_r))
    else $error("active set changed without a commit");

endmodule
`default_nettype wire

@@ src/nfa_epsilon_acceptor.sv @@
// Top level of the epsilon-NFA acceptor: stream ports, output register and unit wiring.
// A table write passes a write state before delivery; a restart seeds the start state and
// runs closure rounds; a feed clears the set, reads successors, drains, then runs closure.
// Throughput: one word at a time; feed time is set by one table read per state on the
// single-port symbol table plus one epsilon closure round per cycle until the set settles.
// Reset (synchronous, active low) empties the active set and both tables and zeroes config.
`default_nettype none
module nfa_epsilon_acceptor (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // operation[1:0], state_index[5:2], symbol_index[9:6], target_mask[25:10]
  input  wire logic [nfa_pkg::IN_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // accepted[0], active_states[16:1], no_live_state[17]
  output logic [nfa_pkg::OUT_W-1:0]       out_tdata,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [nfa_pkg::CFG_W-1:0]  cfg_wdata
);
  import nfa_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  op_t               in_op;
  logic              slot_free;
  logic              res_accepted;
  logic [MASK_W-1:0] res_active;
  logic              res_empty;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  assign in_op     = op_t'(in_tdata[1:0]);
  assign slot_free = !out_valid_r || out_tready;

  nfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_op),
    .slot_free (slot_free),
    .sts       (sts),
    .in_ready  (in_tready),
    .cmd       (cmd)
  );

  nfa_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_op        (in_op),
    .in_state     (in_tdata[5:2]),
    .in_symbol    (in_tdata[9:6]),
    .in_target    (in_tdata[25:10]),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_idx_t'(cfg_index)),
    .cfg_wdata    (cfg_wdata),
    .sts          (sts),
    .res_accepted (res_accepted),
    .res_active   (res_active),
    .res_empty    (res_empty)
  );

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_data_r <= {6'd0, res_empty, res_active, res_accepted};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17] == (out_tdata[16:1] == '0)))
    else $error("empty flag disagrees with the reported set");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[16:1] != '0))
    else $error("accepted reported with no active state");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deliver |=> out_tvalid)
    else $error("delivered result not presented");

endmodule
`default_nettype wire
